// ===== sv/jkv_pkg.sv =====
// shared constants, register indexes and the result record for the key/value extractor
// no dependencies
package jkv_pkg;

    localparam int NUM_PATTERNS    = 4;
    localparam int DEF_NUM_TOKENS  = 4;
    localparam int DEF_MAX_PATTERN = 8;
    localparam int DEF_MAX_VALUES  = 16;

    localparam int BYTE_W        = 8;
    localparam int PATTERN_W     = 64;
    localparam int LEN_W         = 4;
    localparam int LENGTHS_W     = 16;
    localparam int POS_W         = 3;
    localparam int COUNT_CFG_W   = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int TOKEN_IDX_W   = 2;
    localparam int VALUE_IDX_W   = 4;
    localparam int ACT_W         = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ZERO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ONE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_TWO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_THREE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTHS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_COUNT     = 3'd5;

    localparam logic [BYTE_W-1:0] CHAR_QUOTE    = 8'h22;
    localparam logic [BYTE_W-1:0] CHAR_LBRACE   = 8'h7b;
    localparam logic [BYTE_W-1:0] CHAR_RBRACE   = 8'h7d;
    localparam logic [BYTE_W-1:0] CHAR_LBRACKET = 8'h5b;
    localparam logic [BYTE_W-1:0] CHAR_RBRACKET = 8'h5d;
    localparam logic [BYTE_W-1:0] CHAR_COMMA    = 8'h2c;

    typedef struct packed {
        logic [TOKEN_IDX_W-1:0] token_index;
        logic [VALUE_IDX_W-1:0] value_index;
        logic [BYTE_W-1:0]      data_byte;
        logic                   end_of_value;
        logic                   value_overflow;
    } jkv_result_t;

endpackage

// ===== sv/json_key_value_extractor.sv =====
// top level of the key/value extractor: config registers, input register, matchers
// depends on jkv_pkg, jkv_match, jkv_value
//
// Takes one text byte per item and matches up to four configured key patterns in
// parallel; after a key completes, the next byte picks the closing delimiter and the
// value bytes come out one item each, followed by an end-of-value item. Throughput is
// one byte per clock while results are taken: all matchers compare against the input
// register in the same cycle and the priority logic writes the result register. An item
// that yields no result still passes through the input register, and a result waiting
// on m_ready holds the next byte in the input register. Configuration is written via
// cfg_wr_en / cfg_index / cfg_data; the user must write it only while idle, and the
// block itself does not enforce this.
module json_key_value_extractor import jkv_pkg::*; #(
    parameter int NUM_TOKENS  = DEF_NUM_TOKENS,
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int MAX_VALUES  = DEF_MAX_VALUES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [BYTE_W-1:0]      s_char_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [TOKEN_IDX_W-1:0] m_token_index,
    output logic [VALUE_IDX_W-1:0] m_value_index,
    output logic [BYTE_W-1:0]      m_data_byte,
    output logic                   m_end_of_value,
    output logic                   m_value_overflow
);

    logic [PATTERN_W-1:0]   pattern_reg [NUM_PATTERNS];
    logic [LENGTHS_W-1:0]   lengths_reg;
    logic [COUNT_CFG_W-1:0] token_count_reg;
    logic                   in_valid_reg;
    logic [BYTE_W-1:0]      in_byte_reg;
    logic                   fire;
    logic [NUM_TOKENS-1:0]  done;
    logic [NUM_TOKENS-1:0]  update;
    logic [PATTERN_W-1:0]   tok_pattern [NUM_TOKENS];
    logic [LEN_W-1:0]       tok_len [NUM_TOKENS];
    jkv_result_t            result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PATTERNS; i++) begin
                pattern_reg[i] <= '0;
            end
            lengths_reg     <= '0;
            token_count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PATTERN_ZERO:    pattern_reg[0]  <= cfg_data;
                REG_PATTERN_ONE:     pattern_reg[1]  <= cfg_data;
                REG_PATTERN_TWO:     pattern_reg[2]  <= cfg_data;
                REG_PATTERN_THREE:   pattern_reg[3]  <= cfg_data;
                REG_PATTERN_LENGTHS: lengths_reg     <= cfg_data[LENGTHS_W-1:0];
                REG_TOKEN_COUNT:     token_count_reg <= cfg_data[COUNT_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign fire    = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_char_byte;
        end
    end

    for (genvar g = 0; g < NUM_TOKENS; g++) begin : g_tok
        if (g < NUM_PATTERNS) begin : g_cfg
            assign tok_pattern[g] = pattern_reg[g];
            assign tok_len[g]     = lengths_reg[LEN_W*g +: LEN_W];
        end else begin : g_none
            assign tok_pattern[g] = '0;
            assign tok_len[g]     = '0;
        end

        jkv_match #(
            .MAX_PATTERN (MAX_PATTERN)
        ) u_match (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .pattern   (tok_pattern[g]),
            .len_raw   (tok_len[g]),
            .char_byte (in_byte_reg),
            .update    (fire && update[g]),
            .done      (done[g])
        );
    end

    jkv_value #(
        .NUM_TOKENS (NUM_TOKENS),
        .MAX_VALUES (MAX_VALUES)
    ) u_value (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .char_byte   (in_byte_reg),
        .token_count (token_count_reg),
        .done        (done),
        .update      (update),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_result    (result)
    );

    assign m_token_index    = result.token_index;
    assign m_value_index    = result.value_index;
    assign m_data_byte      = result.data_byte;
    assign m_end_of_value   = result.end_of_value;
    assign m_value_overflow = result.value_overflow;

endmodule

// ===== sv/jkv_match.sv =====
// match position tracker for one key pattern, naive restart on mismatch
// depends on jkv_pkg
module jkv_match import jkv_pkg::*; #(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [PATTERN_W-1:0] pattern,
    input  logic [LEN_W-1:0]     len_raw,
    input  logic [BYTE_W-1:0]    char_byte,
    input  logic                 update,
    output logic                 done
);

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] cur_byte;
    logic [BYTE_W-1:0] first_byte;
    logic              hit;

    always_comb begin
        len        = (len_raw > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_raw;
        cur_byte   = (LEN_W'(pos_reg) < len) ? pattern[{pos_reg, 3'b000} +: BYTE_W] : '0;
        first_byte = (len != '0) ? pattern[BYTE_W-1:0] : '0;
        hit        = (cur_byte == char_byte);
        done       = hit && ((LEN_W'(pos_reg) + LEN_W'(1)) == len);
        if (hit) begin
            pos_next = done ? '0 : pos_reg + POS_W'(1);
        end else begin
            pos_next = (first_byte == char_byte) ? POS_W'(1) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (update) begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== sv/jkv_value.sv =====
// value capture control: token priority, delimiter choice, value counts, result register
// depends on jkv_pkg
module jkv_value import jkv_pkg::*; #(
    parameter int NUM_TOKENS = DEF_NUM_TOKENS,
    parameter int MAX_VALUES = DEF_MAX_VALUES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   fire,
    input  logic [BYTE_W-1:0]      char_byte,
    input  logic [COUNT_CFG_W-1:0] token_count,
    input  logic [NUM_TOKENS-1:0]  done,
    output logic [NUM_TOKENS-1:0]  update,
    input  logic                   m_ready,
    output logic                   m_valid,
    output jkv_result_t            m_result
);

    localparam int RW = (NUM_TOKENS > 1) ? $clog2(NUM_TOKENS) : 1;
    localparam int CW = $clog2(MAX_VALUES + 1);

    logic              rv_reg, rv_next;
    logic [RW-1:0]     rt_reg, rt_next;
    logic              dv_reg, dv_next;
    logic [BYTE_W-1:0] cd_reg, cd_next;
    logic [CW-1:0]     cnt_reg [NUM_TOKENS];
    logic              m_valid_reg;
    jkv_result_t       result_reg, result_next;

    logic [ACT_W-1:0]  act;
    logic              lower_done;
    logic              serve;
    logic              early;
    logic              emit;
    logic              eov;
    logic              over;
    logic              any_done;
    logic [RW-1:0]     new_rt;
    logic [BYTE_W-1:0] delim_sel;
    logic [BYTE_W-1:0] close_eff;
    logic [CW-1:0]     cnt_cur;

    always_comb begin
        case (char_byte)
            CHAR_QUOTE:    delim_sel = CHAR_QUOTE;
            CHAR_LBRACE:   delim_sel = CHAR_RBRACE;
            CHAR_LBRACKET: delim_sel = CHAR_RBRACKET;
            default:       delim_sel = CHAR_COMMA;
        endcase
    end

    always_comb begin
        act = (ACT_W'(token_count) > ACT_W'(NUM_TOKENS)) ? ACT_W'(NUM_TOKENS)
                                                          : ACT_W'(token_count);
        lower_done = 1'b0;
        for (int i = 0; i < NUM_TOKENS; i++) begin
            if (RW'(i) < rt_reg) begin
                lower_done = lower_done | done[i];
            end
        end
        serve     = rv_reg && (ACT_W'(rt_reg) < act) && !lower_done;
        early     = serve && !dv_reg && (delim_sel != CHAR_COMMA);
        emit      = serve && !early;
        close_eff = dv_reg ? cd_reg : CHAR_COMMA;
        eov       = (char_byte == close_eff);
        cnt_cur   = cnt_reg[rt_reg];
        over      = (cnt_cur >= CW'(MAX_VALUES));

        any_done = 1'b0;
        new_rt   = rt_reg;
        for (int i = 0; i < NUM_TOKENS; i++) begin
            update[i] = (ACT_W'(i) < act) && !(serve && (RW'(i) == rt_reg))
                        && !(early && (RW'(i) > rt_reg));
            if (update[i] && done[i]) begin
                any_done = 1'b1;
                new_rt   = RW'(i);
            end
        end

        rv_next = rv_reg;
        rt_next = rt_reg;
        dv_next = dv_reg;
        cd_next = cd_reg;
        if (serve && !dv_reg) begin
            cd_next = delim_sel;
        end
        if (any_done) begin
            rv_next = 1'b1;
            rt_next = new_rt;
            dv_next = emit ? !eov : dv_reg;
        end else if (early) begin
            dv_next = 1'b1;
        end else if (emit) begin
            rv_next = !eov;
            dv_next = !eov;
        end

        result_next.token_index    = TOKEN_IDX_W'(rt_reg);
        result_next.value_index    = over ? '0 : VALUE_IDX_W'(cnt_cur);
        result_next.data_byte      = eov ? '0 : char_byte;
        result_next.end_of_value   = eov;
        result_next.value_overflow = over;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg      <= 1'b0;
            rt_reg      <= '0;
            dv_reg      <= 1'b0;
            cd_reg      <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TOKENS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            if (fire) begin
                rv_reg <= rv_next;
                rt_reg <= rt_next;
                dv_reg <= dv_next;
                cd_reg <= cd_next;
                if (emit && eov && !over) begin
                    cnt_reg[rt_reg] <= cnt_cur + CW'(1);
                end
            end
            if (fire && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            result_reg <= result_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

`ifndef SYNTHESIS
    a_delim_needs_read: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_reg |-> rv_reg)
        else $error("delimiter chosen with no value being read");

    a_result_from_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(fire))
        else $error("result appeared without an item being processed");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        rv_reg |-> (cnt_reg[rt_reg] <= CW'(MAX_VALUES)))
        else $error("value count beyond saturation");

    a_no_fire_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !fire)
        else $error("item processed while result register is blocked");
`endif

endmodule
